### hdl/dpw_pkg.sv
package dpw_pkg;

  localparam int unsigned CFG_W      = 63;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CENTER_W   = 16;
  localparam int unsigned FOCAL_W    = 48;
  localparam int unsigned ROT_W      = 16;
  localparam int unsigned ROT_ROW_W  = 3 * ROT_W;
  localparam int unsigned TRANS_W    = 21;
  localparam int unsigned TRANS_ALL_W = 3 * TRANS_W;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned CAM_W      = 46;
  localparam int unsigned PROD_W     = ROT_W + CAM_W;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned WORLD_W    = 32;
  localparam int unsigned PIPE_DEPTH = 7;

  localparam logic [CAM_W-2:0] CAM_LIMIT = '1;

  localparam logic [SCALE_W-1:0]     RST_INV_DEPTH_SCALE = 24'd16777;
  localparam logic [CENTER_W-1:0]    RST_PRINCIPAL_X     = 16'd5208;
  localparam logic [CENTER_W-1:0]    RST_PRINCIPAL_Y     = 16'd4056;
  localparam logic [FOCAL_W-1:0]     RST_INV_FOCAL       = 48'd543380504196;
  localparam logic [ROT_ROW_W-1:0]   RST_ROT_ROW_X       = 48'd16384;
  localparam logic [ROT_ROW_W-1:0]   RST_ROT_ROW_Y       = 48'd1073741824;
  localparam logic [ROT_ROW_W-1:0]   RST_ROT_ROW_Z       = 48'd70368744177664;
  localparam logic [TRANS_ALL_W-1:0] RST_TRANSLATION     = '0;

  typedef enum logic [2:0] {
    CFG_INV_DEPTH_SCALE,
    CFG_PRINCIPAL_X,
    CFG_PRINCIPAL_Y,
    CFG_INV_FOCAL,
    CFG_ROT_ROW_X,
    CFG_ROT_ROW_Y,
    CFG_ROT_ROW_Z,
    CFG_TRANSLATION
  } cfg_idx_e;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

endpackage

### hdl/depth_pixel_to_world_point.sv
// Back-projects one depth pixel per clock through pinhole intrinsics and a rigid
// transform into a signed Q16.16 world point, saturated, with the color passed
// along. A word is taken at every clock edge where start is high; busy is tied
// low because the seven-stage pipeline always advances. A pixel with nonzero
// depth gives its result on the world and color ports, marked by strobe_o; a
// pixel with zero depth is taken and gives no result. The receiver cannot
// stall, so results must be taken in the cycle they appear. There is one
// register stage each for the depth scaling and principal point offsets, the
// focal reciprocal multiply, the multiply by depth, the rounding and sign of
// the camera point, the nine rotation multiplies, the row sums, and the final
// scaling and saturation.
module depth_pixel_to_world_point #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [COORD_BITS-1:0]                 pixel_col_i,
  input  logic [COORD_BITS-1:0]                 pixel_row_i,
  input  logic [dpw_pkg::DEPTH_W-1:0]           raw_depth_i,
  input  logic [dpw_pkg::COLOR_W-1:0]           in_blue_i,
  input  logic [dpw_pkg::COLOR_W-1:0]           in_green_i,
  input  logic [dpw_pkg::COLOR_W-1:0]           in_red_i,
  input  logic                                  cfg_we_i,
  input  dpw_pkg::cfg_idx_e                     cfg_index_i,
  input  logic [dpw_pkg::CFG_W-1:0]             cfg_wdata_i,
  output logic                                  strobe_o,
  output logic signed [dpw_pkg::WORLD_W-1:0]    world_x_o,
  output logic signed [dpw_pkg::WORLD_W-1:0]    world_y_o,
  output logic signed [dpw_pkg::WORLD_W-1:0]    world_z_o,
  output logic [dpw_pkg::COLOR_W-1:0]           out_blue_o,
  output logic [dpw_pkg::COLOR_W-1:0]           out_green_o,
  output logic [dpw_pkg::COLOR_W-1:0]           out_red_o
);
  import dpw_pkg::*;

  localparam int unsigned MAG_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
  localparam int unsigned DU_W  = MAG_W + 1;
  localparam int unsigned RXP_W = MAG_W + SCALE_W;
  localparam int unsigned R_W   = MAG_W + 12;
  localparam int unsigned RZP_W = R_W + Z_W;
  localparam int unsigned ZP_W  = DEPTH_W + SCALE_W;

  // Configuration registers.
  logic [SCALE_W-1:0]     scale_q;
  logic [CENTER_W-1:0]    center_q [2];
  logic [FOCAL_W-1:0]     focal_q;
  logic [ROT_ROW_W-1:0]   rot_q [3];
  logic [TRANS_ALL_W-1:0] trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= RST_INV_DEPTH_SCALE;
      center_q[0] <= RST_PRINCIPAL_X;
      center_q[1] <= RST_PRINCIPAL_Y;
      focal_q     <= RST_INV_FOCAL;
      rot_q[0]    <= RST_ROT_ROW_X;
      rot_q[1]    <= RST_ROT_ROW_Y;
      rot_q[2]    <= RST_ROT_ROW_Z;
      trans_q     <= RST_TRANSLATION;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INV_DEPTH_SCALE: scale_q     <= cfg_wdata_i[SCALE_W-1:0];
        CFG_PRINCIPAL_X:     center_q[0] <= cfg_wdata_i[CENTER_W-1:0];
        CFG_PRINCIPAL_Y:     center_q[1] <= cfg_wdata_i[CENTER_W-1:0];
        CFG_INV_FOCAL:       focal_q     <= cfg_wdata_i[FOCAL_W-1:0];
        CFG_ROT_ROW_X:       rot_q[0]    <= cfg_wdata_i[ROT_ROW_W-1:0];
        CFG_ROT_ROW_Y:       rot_q[1]    <= cfg_wdata_i[ROT_ROW_W-1:0];
        CFG_ROT_ROW_Z:       rot_q[2]    <= cfg_wdata_i[ROT_ROW_W-1:0];
        CFG_TRANSLATION:     trans_q     <= cfg_wdata_i[TRANS_ALL_W-1:0];
        default:             scale_q     <= scale_q;
      endcase
    end
  end

  assign busy = 1'b0;

  // Valid bits and color travel with the pixel.
  logic   valid_q [1:PIPE_DEPTH];
  color_t color_q [1:PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= PIPE_DEPTH; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      valid_q[1] <= start && (raw_depth_i != '0);
      for (int s = 2; s <= PIPE_DEPTH; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    color_q[1] <= '{blue: in_blue_i, green: in_green_i, red: in_red_i};
    for (int s = 2; s <= PIPE_DEPTH; s++) begin
      color_q[s] <= color_q[s-1];
    end
  end

  // Stage 1: depth times scale, pixel offsets from the principal point.
  logic [ZP_W-1:0]  zp1_q;
  logic [MAG_W-1:0] mag1_q [2];
  logic             neg1_q [2];
  logic [DU_W-1:0]  du1 [2];
  logic [DU_W-1:0]  pix_ext [2];

  always_comb begin
    pix_ext[0] = DU_W'({pixel_col_i, 4'b0000});
    pix_ext[1] = DU_W'({pixel_row_i, 4'b0000});
    for (int k = 0; k < 2; k++) begin
      du1[k] = pix_ext[k] - DU_W'(center_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    zp1_q <= ZP_W'(raw_depth_i) * ZP_W'(scale_q);
    for (int k = 0; k < 2; k++) begin
      neg1_q[k] <= du1[k][DU_W-1];
      mag1_q[k] <= du1[k][DU_W-1] ? MAG_W'(-du1[k]) : du1[k][MAG_W-1:0];
    end
  end

  // Stage 2: rounded depth, offsets times focal reciprocals.
  logic [Z_W-1:0]   z2_q;
  logic [RXP_W-1:0] rp2_q [2];
  logic             neg2_q [2];
  logic [ZP_W-1:0]  zr2;

  always_comb begin
    zr2 = zp1_q + ZP_W'(128);
  end

  always_ff @(posedge clk_i) begin
    z2_q      <= zr2[ZP_W-1:8];
    rp2_q[0]  <= RXP_W'(mag1_q[0]) * RXP_W'(focal_q[SCALE_W-1:0]);
    rp2_q[1]  <= RXP_W'(mag1_q[1]) * RXP_W'(focal_q[FOCAL_W-1:SCALE_W]);
    neg2_q    <= neg1_q;
  end

  // Stage 3: rounded ray slope times depth.
  logic [Z_W-1:0]   z3_q;
  logic [RZP_W-1:0] rzp3_q [2];
  logic             neg3_q [2];
  logic [RXP_W-1:0] rr3 [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rr3[k] = rp2_q[k] + RXP_W'(2048);
    end
  end

  always_ff @(posedge clk_i) begin
    z3_q <= z2_q;
    for (int k = 0; k < 2; k++) begin
      rzp3_q[k] <= RZP_W'(rr3[k][RXP_W-1:12]) * RZP_W'(z2_q);
    end
    neg3_q <= neg2_q;
  end

  // Stage 4: rounded camera point, magnitude limit, sign restored.
  logic signed [CAM_W-1:0] cam4_q [3];
  logic [RZP_W-1:0]        rc4 [2];
  logic [47:0]             c4 [2];
  logic [CAM_W-2:0]        cs4 [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rc4[k] = rzp3_q[k] + RZP_W'(32768);
      c4[k]  = 48'(rc4[k][RZP_W-1:16]);
      cs4[k] = (c4[k] > 48'(CAM_LIMIT)) ? CAM_LIMIT : c4[k][CAM_W-2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      cam4_q[k] <= neg3_q[k] ? -$signed({1'b0, cs4[k]}) : $signed({1'b0, cs4[k]});
    end
    cam4_q[2] <= $signed(CAM_W'(z3_q));
  end

  // Stage 5: the nine rotation products.
  logic signed [PROD_W-1:0] prod5_q [3][3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod5_q[i][j] <= $signed(rot_q[i][ROT_W*j +: ROT_W]) * cam4_q[j];
      end
    end
  end

  // Stage 6: row sums with translation and rounding offset.
  logic signed [ACC_W-1:0] acc6_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      acc6_q[i] <= ACC_W'(prod5_q[i][0]) + ACC_W'(prod5_q[i][1]) + ACC_W'(prod5_q[i][2])
                 + ACC_W'($signed({trans_q[TRANS_W*i +: TRANS_W], 20'b0}))
                 + ACC_W'(signed'(15'sd8192));
    end
  end

  // Stage 7: scale down and saturate.
  logic signed [WORLD_W-1:0]    world7_q [3];
  logic signed [ACC_W-15:0]     sh7 [3];
  logic signed [WORLD_W-1:0]    sat7 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh7[i] = acc6_q[i][ACC_W-1:14];
      if (!sh7[i][ACC_W-15] && (|sh7[i][ACC_W-16:WORLD_W-1])) begin
        sat7[i] = {1'b0, {(WORLD_W-1){1'b1}}};
      end else if (sh7[i][ACC_W-15] && !(&sh7[i][ACC_W-16:WORLD_W-1])) begin
        sat7[i] = {1'b1, {(WORLD_W-1){1'b0}}};
      end else begin
        sat7[i] = sh7[i][WORLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    world7_q <= sat7;
  end

  assign strobe_o    = valid_q[PIPE_DEPTH];
  assign world_x_o   = world7_q[0];
  assign world_y_o   = world7_q[1];
  assign world_z_o   = world7_q[2];
  assign out_blue_o  = color_q[PIPE_DEPTH].blue;
  assign out_green_o = color_q[PIPE_DEPTH].green;
  assign out_red_o   = color_q[PIPE_DEPTH].red;

endmodule

### hdl/dpw_checker.sv
module dpw_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [dpw_pkg::DEPTH_W-1:0]  raw_depth_i,
  input  logic [dpw_pkg::COLOR_W-1:0]  in_blue_i,
  input  logic [dpw_pkg::COLOR_W-1:0]  in_red_i,
  input  logic                         strobe_o,
  input  logic [dpw_pkg::COLOR_W-1:0]  out_blue_o,
  input  logic [dpw_pkg::COLOR_W-1:0]  out_red_o
);
  import dpw_pkg::*;

  // The pipeline never holds off a new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && (raw_depth_i != '0) |-> ##PIPE_DEPTH strobe_o)
    else $error("result missing for a pixel with depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && (raw_depth_i != '0), PIPE_DEPTH))
    else $error("result without a matching pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (out_blue_o == $past(in_blue_i, PIPE_DEPTH))
                 && (out_red_o == $past(in_red_i, PIPE_DEPTH)))
    else $error("color not carried with its point");

endmodule

bind depth_pixel_to_world_point dpw_checker u_dpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .raw_depth_i (raw_depth_i),
  .in_blue_i   (in_blue_i),
  .in_red_i    (in_red_i),
  .strobe_o    (strobe_o),
  .out_blue_o  (out_blue_o),
  .out_red_o   (out_red_o)
);
